[hw/rtl/arpc_pkg.sv]
// ----------------------------------------------------------------------------
// ARP cache package
// Shared types and constants for the ARP cache responder.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int unsigned IP_W  = 32;
  localparam int unsigned MAC_W = 48;
  localparam int unsigned IDX_W = 6;
  localparam int unsigned OPC_W = 16;

  localparam logic [OPC_W-1:0] OPCODE_REQUEST = 16'd1;
  localparam logic [OPC_W-1:0] OPCODE_REPLY   = 16'd2;

  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  localparam logic CFG_OWN_IP  = 1'b0;
  localparam logic CFG_OWN_MAC = 1'b1;

  typedef enum logic [1:0] {
    ARPC_NONE,
    ARPC_LOOKUP,
    ARPC_REQUEST,
    ARPC_REPLY
  } arpc_op_t;

  typedef struct packed {
    arpc_op_t         op;
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  ip;
  } arpc_item_t;

endpackage

[hw/rtl/arpc_front.sv]
// ----------------------------------------------------------------------------
// ARP cache front end
// Holds own_ip and sorts each incoming word into lookup, request, reply or
// no-op before it is queued.
// ----------------------------------------------------------------------------
module arpc_front import arpc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [MAC_W-1:0] cfg_data,
  input  logic             kind,
  input  logic [OPC_W-1:0] opcode,
  input  logic [MAC_W-1:0] sender_mac,
  input  logic [IP_W-1:0]  sender_ip,
  input  logic [IP_W-1:0]  target_ip,
  input  logic [IP_W-1:0]  query_ip,
  output arpc_item_t       item
);

  logic [IP_W-1:0] own_ip;

  // own_mac is not kept here; a write to it has no effect in this block
  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OWN_IP:  own_ip <= cfg_data[IP_W-1:0];
        CFG_OWN_MAC: ;
        default:     ;
      endcase
    end
  end

  always_comb begin
    item.mac = sender_mac;
    item.ip  = sender_ip;
    item.op  = ARPC_NONE;
    if (kind == KIND_LOOKUP) begin
      item.op = ARPC_LOOKUP;
      item.ip = query_ip;
    end else if (target_ip == own_ip) begin
      if (opcode == OPCODE_REQUEST) begin
        item.op = ARPC_REQUEST;
      end else if (opcode == OPCODE_REPLY) begin
        item.op = ARPC_REPLY;
      end
    end
  end

endmodule

[hw/rtl/arpc_queue.sv]
// ----------------------------------------------------------------------------
// ARP cache work queue
// Two-entry queue between the front end and the table engine.
// ----------------------------------------------------------------------------
module arpc_queue import arpc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  arpc_item_t push_item,
  input  logic       pop,
  output logic       full,
  output logic       not_empty,
  output arpc_item_t pop_item
);

  arpc_item_t  mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_push;
  logic        do_pop;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hw/rtl/arpc_back.sv]
// ----------------------------------------------------------------------------
// ARP cache table engine
// Holds the IP-to-MAC table and insert pointer, runs one queued word per
// cycle and registers its result.
// ----------------------------------------------------------------------------
module arpc_back import arpc_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  arpc_item_t       item,
  output logic             done,
  output logic             send_reply,
  output logic [MAC_W-1:0] reply_target_mac,
  output logic [IP_W-1:0]  reply_target_ip,
  output logic             found,
  output logic [IDX_W-1:0] entry_index,
  output logic [MAC_W-1:0] found_mac
);

  localparam int unsigned PTR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [PTR_W-1:0] LAST = PTR_W'(TABLE_ENTRIES - 1);

  logic [IP_W-1:0]  ip_tab  [TABLE_ENTRIES];
  logic [MAC_W-1:0] mac_tab [TABLE_ENTRIES];
  logic [PTR_W-1:0] insert_ptr;
  logic [PTR_W-1:0] insert_ptr_next;

  logic             hit;
  logic [PTR_W-1:0] hit_idx;
  logic [PTR_W-1:0] slot;
  logic             wr_en;
  logic             adv;

  logic             send_reply_next;
  logic [MAC_W-1:0] reply_target_mac_next;
  logic [IP_W-1:0]  reply_target_ip_next;
  logic             found_next;
  logic [IDX_W-1:0] entry_index_next;
  logic [MAC_W-1:0] found_mac_next;

  // lowest matching slot wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (ip_tab[i] == item.ip) begin
        hit     = 1'b1;
        hit_idx = PTR_W'(i);
      end
    end
  end

  assign insert_ptr_next = (insert_ptr == LAST) ? '0 : insert_ptr + PTR_W'(1);
  assign slot            = hit ? hit_idx : insert_ptr;

  always_comb begin
    wr_en                 = 1'b0;
    adv                   = 1'b0;
    send_reply_next       = 1'b0;
    reply_target_mac_next = '0;
    reply_target_ip_next  = '0;
    found_next            = 1'b0;
    entry_index_next      = '0;
    found_mac_next        = '0;
    unique case (item.op)
      ARPC_LOOKUP: begin
        if (hit) begin
          found_next       = 1'b1;
          entry_index_next = IDX_W'(hit_idx);
          found_mac_next   = mac_tab[hit_idx];
        end
      end
      ARPC_REQUEST: begin
        wr_en                 = 1'b1;
        adv                   = !hit;
        send_reply_next       = 1'b1;
        reply_target_mac_next = item.mac;
        reply_target_ip_next  = item.ip;
        entry_index_next      = IDX_W'(slot);
      end
      ARPC_REPLY: begin
        if (!hit) begin
          wr_en            = 1'b1;
          adv              = 1'b1;
          entry_index_next = IDX_W'(insert_ptr);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        ip_tab[i]  <= '0;
        mac_tab[i] <= '0;
      end
      insert_ptr <= '0;
      done       <= 1'b0;
    end else begin
      done <= item_valid;
      if (item_valid && wr_en) begin
        ip_tab[slot]  <= item.ip;
        mac_tab[slot] <= item.mac;
      end
      if (item_valid && adv) begin
        insert_ptr <= insert_ptr_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid) begin
      send_reply       <= send_reply_next;
      reply_target_mac <= reply_target_mac_next;
      reply_target_ip  <= reply_target_ip_next;
      found            <= found_next;
      entry_index      <= entry_index_next;
      found_mac        <= found_mac_next;
    end
  end

endmodule

[hw/rtl/arp_cache_responder.sv]
// ----------------------------------------------------------------------------
// ARP cache responder
// Small IP-to-MAC table, filled round robin, that answers ARP requests and
// table lookups.
// ----------------------------------------------------------------------------
// Use:
//   A word is taken at a rising edge with start high and busy low. kind
//   selects a parsed ARP packet (opcode, sender_mac, sender_ip, target_ip)
//   or a lookup of query_ip. Every word gives exactly one result, shown for
//   one cycle with done high; the receiver cannot stall it.
//   own_ip and own_mac are written through cfg_we / cfg_index / cfg_data
//   while no word is in flight.
//   A word passes through the two-entry queue and then the table engine's
//   output register before its result is shown with done high.
//   Throughput: one word per cycle; the table engine compares all entries in
//   parallel and updates the table in the same cycle, so the queue never
//   holds more than one word and busy stays low.
//   Reset (rst, synchronous) clears the table to zero, the insert pointer,
//   own_ip and the queue. Empty slots hold IP 0, so a lookup of IP 0 hits.
// ----------------------------------------------------------------------------
module arp_cache_responder import arpc_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [MAC_W-1:0] cfg_data,
  input  logic             start,
  output logic             busy,
  input  logic             kind,
  input  logic [OPC_W-1:0] opcode,
  input  logic [MAC_W-1:0] sender_mac,
  input  logic [IP_W-1:0]  sender_ip,
  input  logic [IP_W-1:0]  target_ip,
  input  logic [IP_W-1:0]  query_ip,
  output logic             done,
  output logic             send_reply,
  output logic [MAC_W-1:0] reply_target_mac,
  output logic [IP_W-1:0]  reply_target_ip,
  output logic             found,
  output logic [IDX_W-1:0] entry_index,
  output logic [MAC_W-1:0] found_mac
);

  arpc_item_t in_item;
  arpc_item_t q_item;
  logic       q_full;
  logic       q_valid;

  assign busy = q_full;

  arpc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .kind       (kind),
    .opcode     (opcode),
    .sender_mac (sender_mac),
    .sender_ip  (sender_ip),
    .target_ip  (target_ip),
    .query_ip   (query_ip),
    .item       (in_item)
  );

  arpc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (start),
    .push_item (in_item),
    .pop       (1'b1),
    .full      (q_full),
    .not_empty (q_valid),
    .pop_item  (q_item)
  );

  arpc_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (q_valid),
    .item             (q_item),
    .done             (done),
    .send_reply       (send_reply),
    .reply_target_mac (reply_target_mac),
    .reply_target_ip  (reply_target_ip),
    .found            (found),
    .entry_index      (entry_index),
    .found_mac        (found_mac)
  );

endmodule

[hw/rtl/arpc_checker.sv]
// ----------------------------------------------------------------------------
// ARP cache port checker
// Watches the responder's ports: one result per word, in fixed latency, and
// consistent result fields.
// ----------------------------------------------------------------------------
module arpc_checker import arpc_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input logic             send_reply,
  input logic             found,
  input logic [MAC_W-1:0] found_mac
);

  a_result_follows: assert property (
    @(posedge clk) disable iff (rst) (start && !busy) |-> ##2 done
  ) else $error("word taken without a result two cycles later");

  a_no_spurious: assert property (
    @(posedge clk) disable iff (rst) done |-> $past(start && !busy, 2)
  ) else $error("result without a word taken");

  a_reply_not_lookup: assert property (
    @(posedge clk) disable iff (rst) (done && send_reply) |-> !found
  ) else $error("reply and lookup hit in one result");

  a_miss_mac_zero: assert property (
    @(posedge clk) disable iff (rst) (done && !found) |-> (found_mac == '0)
  ) else $error("found_mac non-zero on a miss");

endmodule

bind arp_cache_responder arpc_checker u_arpc_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .send_reply (send_reply),
  .found      (found),
  .found_mac  (found_mac)
);

[tb/arp_cache_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache checker
// Watches the configuration port and both sides of the ARP cache responder.
// For every word taken it works out the answer from its own copy of the
// table, insert pointer and station address, and compares each result
// field by field with the oldest answer still due.
// ----------------------------------------------------------------------------
module arp_cache_checker import arpc_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [MAC_W-1:0] cfg_data,
  input  logic             start,
  input  logic             busy,
  input  logic             kind,
  input  logic [OPC_W-1:0] opcode,
  input  logic [MAC_W-1:0] sender_mac,
  input  logic [IP_W-1:0]  sender_ip,
  input  logic [IP_W-1:0]  target_ip,
  input  logic [IP_W-1:0]  query_ip,
  input  logic             done,
  input  logic             send_reply,
  input  logic [MAC_W-1:0] reply_target_mac,
  input  logic [IP_W-1:0]  reply_target_ip,
  input  logic             found,
  input  logic [IDX_W-1:0] entry_index,
  input  logic [MAC_W-1:0] found_mac,
  output int               mismatches,
  output int               outstanding
);

  typedef struct packed {
    logic             reply;
    logic [MAC_W-1:0] reply_mac;
    logic [IP_W-1:0]  reply_ip;
    logic             hit;
    logic [IDX_W-1:0] index;
    logic [MAC_W-1:0] hit_mac;
  } arp_answer_t;

  logic [IP_W-1:0]  ip_tab  [TABLE_ENTRIES];
  logic [MAC_W-1:0] mac_tab [TABLE_ENTRIES];
  int unsigned      next_slot;
  logic [IP_W-1:0]  station_ip;
  logic [MAC_W-1:0] station_mac;
  arp_answer_t      answers_due [$];

  // lowest matching index wins
  function automatic bit locate(input logic [IP_W-1:0] ip, output int unsigned pos);
    pos = 0;
    for (int unsigned i = 0; i < TABLE_ENTRIES; i++) begin
      if (ip_tab[i] == ip) begin
        pos = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic int unsigned claim_slot();
    int unsigned slot;
    slot = (next_slot >= TABLE_ENTRIES) ? 0 : next_slot;
    next_slot = (slot + 1 >= TABLE_ENTRIES) ? 0 : slot + 1;
    return slot;
  endfunction

  task automatic resolve_arp_word();
    arp_answer_t a;
    int unsigned pos;
    bit          known;
    a = '0;
    if (kind == KIND_LOOKUP) begin
      if (locate(query_ip, pos)) begin
        a.hit     = 1'b1;
        a.index   = pos[IDX_W-1:0];
        a.hit_mac = mac_tab[pos];
      end
    end else if (target_ip == station_ip) begin
      known = locate(sender_ip, pos);
      if (opcode == OPCODE_REQUEST) begin
        if (!known) pos = claim_slot();
        ip_tab[pos]  = sender_ip;
        mac_tab[pos] = sender_mac;
        a.reply      = 1'b1;
        a.reply_mac  = sender_mac;
        a.reply_ip   = sender_ip;
        a.index      = pos[IDX_W-1:0];
      end else if (opcode == OPCODE_REPLY && !known) begin
        pos          = claim_slot();
        ip_tab[pos]  = sender_ip;
        mac_tab[pos] = sender_mac;
        a.index      = pos[IDX_W-1:0];
      end
    end
    answers_due.push_back(a);
  endtask

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    arp_answer_t a;
    if (rst) begin
      for (int unsigned i = 0; i < TABLE_ENTRIES; i++) begin
        ip_tab[i]  = '0;
        mac_tab[i] = '0;
      end
      next_slot   = 0;
      station_ip  = '0;
      station_mac = '0;
      answers_due.delete();
    end else begin
      if (done) begin
        if (answers_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with no answer due", $realtime);
        end else begin
          a = answers_due.pop_front();
          check_field("send_reply", a.reply, send_reply);
          check_field("reply_target_mac", a.reply_mac, reply_target_mac);
          check_field("reply_target_ip", a.reply_ip, reply_target_ip);
          check_field("found", a.hit, found);
          check_field("entry_index", a.index, entry_index);
          check_field("found_mac", a.hit_mac, found_mac);
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_OWN_IP) station_ip = cfg_data[IP_W-1:0];
        else station_mac = cfg_data;
      end
      if (start && !busy) resolve_arp_word();
    end
    outstanding = answers_due.size();
  end

endmodule

[tb/tb_arp_cache_responder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache responder testbench
// Directed words for empty slots, refresh, insert, pointer wrap and ignored
// packets, then four phases of random words from a small IP pool with
// different station addresses and sender idling. Checking is done by the
// checker instance; this module drives the block and gives the verdict.
// ----------------------------------------------------------------------------
module tb_arp_cache_responder;
  import arpc_pkg::*;

  localparam int unsigned TABLE_ENTRIES = 8;
  localparam int unsigned POOL_SIZE     = 12;
  localparam int unsigned PHASE_WORDS   = 450;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam logic [IP_W-1:0] DIR_IP    = 32'hC0A8_0001;
  localparam logic [IP_W-1:0] IP_A      = 32'h0A00_0001;
  localparam logic [IP_W-1:0] IP_B      = 32'h0A00_0002;
  localparam logic [IP_W-1:0] IP_FRESH  = 32'h0A00_0010;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic             cfg_index;
  logic [MAC_W-1:0] cfg_data;
  logic             start;
  logic             busy;
  logic             kind;
  logic [OPC_W-1:0] opcode;
  logic [MAC_W-1:0] sender_mac;
  logic [IP_W-1:0]  sender_ip;
  logic [IP_W-1:0]  target_ip;
  logic [IP_W-1:0]  query_ip;
  logic             done;
  logic             send_reply;
  logic [MAC_W-1:0] reply_target_mac;
  logic [IP_W-1:0]  reply_target_ip;
  logic             found;
  logic [IDX_W-1:0] entry_index;
  logic [MAC_W-1:0] found_mac;
  int               mismatches;
  int               outstanding;
  int unsigned      cycle_count = 0;
  logic [IP_W-1:0]  own_ip_now;

  always #5 clk = ~clk;

  arp_cache_responder #(.TABLE_ENTRIES(TABLE_ENTRIES)) DUT (.*);

  arp_cache_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_checker (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[MAC_W-1:0];
  endfunction

  task automatic put_word(input logic k, input logic [OPC_W-1:0] opc,
                          input logic [MAC_W-1:0] smac, input logic [IP_W-1:0] sip,
                          input logic [IP_W-1:0] tip, input logic [IP_W-1:0] qip,
                          input int unsigned gap);
    @(negedge clk);
    kind       = k;
    opcode     = opc;
    sender_mac = smac;
    sender_ip  = sip;
    target_ip  = tip;
    query_ip   = qip;
    start      = 1'b1;
    do @(posedge clk); while (busy);
    if (gap != 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // hold off until every answer is in, then let the pipeline settle
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [MAC_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
    cfg_data  = rand_mac();
  endtask

  task automatic set_station(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac);
    logic [MAC_W-1:0] d;
    drain();
    d = rand_mac();
    d[IP_W-1:0] = ip;
    write_reg(CFG_OWN_IP, d);
    write_reg(CFG_OWN_MAC, mac);
    own_ip_now = ip;
  endtask

  initial begin
    logic [IP_W-1:0]  pool [POOL_SIZE];
    logic [IP_W-1:0]  phase_ip  [4];
    logic [MAC_W-1:0] phase_mac [4];
    int unsigned      idle_pct  [4];
    logic [IP_W-1:0]  sip, tip, qip;
    logic [MAC_W-1:0] smac;
    logic [OPC_W-1:0] opc;
    int unsigned      gap, pick;

    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = CFG_OWN_IP;
    cfg_data   = '0;
    start      = 1'b0;
    kind       = KIND_PACKET;
    opcode     = '0;
    sender_mac = '0;
    sender_ip  = '0;
    target_ip  = '0;
    query_ip   = '0;
    own_ip_now = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty slots hold IP 0, own_ip still at its reset value
    put_word(KIND_LOOKUP, OPC_W'($urandom_range(0, 65535)), rand_mac(), $urandom(),
             $urandom(), '0, 0);
    put_word(KIND_PACKET, OPCODE_REQUEST, rand_mac(), '0, '0, $urandom(), 0);
    set_station(DIR_IP, rand_mac());
    put_word(KIND_PACKET, OPCODE_REQUEST, '1, IP_A, DIR_IP, $urandom(), 0);
    put_word(KIND_PACKET, OPCODE_REQUEST, rand_mac(), IP_A, DIR_IP, '1, 0);
    put_word(KIND_PACKET, OPCODE_REPLY, '0, IP_B, DIR_IP, $urandom(), 0);
    put_word(KIND_PACKET, OPCODE_REPLY, rand_mac(), IP_B, DIR_IP, $urandom(), 0);
    put_word(KIND_PACKET, OPCODE_REQUEST, rand_mac(), 32'h0A00_0003, ~DIR_IP, '0, 0);
    put_word(KIND_PACKET, OPCODE_REPLY, rand_mac(), 32'h0A00_0004, DIR_IP + 1, '0, 0);
    put_word(KIND_PACKET, '0, rand_mac(), 32'h0A00_0005, DIR_IP, $urandom(), 0);
    put_word(KIND_PACKET, '1, '1, '1, DIR_IP, '1, 0);
    put_word(KIND_PACKET, 16'd3, rand_mac(), 32'h0A00_0006, DIR_IP, $urandom(), 0);
    put_word(KIND_LOOKUP, '0, '0, '0, '0, IP_A, 0);
    put_word(KIND_LOOKUP, '1, '1, '1, '1, '0, 0);
    put_word(KIND_LOOKUP, OPC_W'($urandom_range(0, 65535)), rand_mac(), $urandom(),
             $urandom(), '1, 0);
    // eight fresh senders run the insert pointer past the last slot
    for (int unsigned i = 0; i < TABLE_ENTRIES; i++)
      put_word(KIND_PACKET, OPCODE_REPLY, rand_mac(), (i == 0) ? '1 : IP_FRESH + i,
               DIR_IP, $urandom(), 0);
    put_word(KIND_LOOKUP, '0, rand_mac(), $urandom(), $urandom(), IP_A, 0);
    put_word(KIND_LOOKUP, '0, rand_mac(), $urandom(), $urandom(), '1, 0);

    phase_ip[0]  = $urandom();  phase_mac[0] = '1;         idle_pct[0] = 0;
    phase_ip[1]  = '1;          phase_mac[1] = '0;         idle_pct[1] = 66;
    phase_ip[2]  = '0;          phase_mac[2] = rand_mac(); idle_pct[2] = 0;
    phase_ip[3]  = $urandom();  phase_mac[3] = rand_mac(); idle_pct[3] = 36;

    for (int unsigned ph = 0; ph < 4; ph++) begin
      set_station(phase_ip[ph], phase_mac[ph]);
      pool[0] = '0;
      pool[1] = '1;
      pool[2] = own_ip_now;
      for (int unsigned i = 3; i < POOL_SIZE; i++) pool[i] = $urandom();
      for (int unsigned n = 0; n < PHASE_WORDS; n++) begin
        if (n == PHASE_WORDS / 2) drain();
        gap = 0;
        if ((n % 64) >= 16 && $urandom_range(0, 99) < idle_pct[ph])
          gap = $urandom_range(1, 4);
        pick = $urandom_range(0, 99);
        sip  = pool[$urandom_range(0, POOL_SIZE - 1)];
        smac = rand_mac();
        tip  = ($urandom_range(0, 99) < 85) ? own_ip_now : $urandom();
        qip  = ($urandom_range(0, 99) < 80) ? pool[$urandom_range(0, POOL_SIZE - 1)]
                                            : $urandom();
        if (pick < 30) begin
          put_word(KIND_LOOKUP, OPC_W'($urandom_range(0, 65535)), smac, sip, tip, qip,
                   gap);
        end else if (pick < 88) begin
          opc = ($urandom_range(0, 99) < 55) ? OPCODE_REQUEST : OPCODE_REPLY;
          put_word(KIND_PACKET, opc, smac, sip, tip, qip, gap);
        end else begin
          opc = OPC_W'($urandom_range(0, 65535));
          put_word(KIND_PACKET, opc, smac, $urandom(), tip, qip, gap);
        end
      end
    end

    drain();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
